/* hdl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and constants of the barometric pressure compensation block
// ----------------------------------------------------------------------------
package bpc_pkg;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int TRIM_W    = 48;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_TRIM = 3'd0,
    CFG_PRESS_A   = 3'd1,
    CFG_PRESS_B   = 3'd2,
    CFG_PRESS_C   = 3'd3
  } bpc_cfg_t;

  // pressure divider sizes
  localparam int DIV_STEPS = 35;               // quotient bits below the limit
  localparam int NUM_W     = 78;               // scaled numerator magnitude
  localparam int DEN_W     = 42;               // divisor magnitude
  localparam int QUOT_W    = DIV_STEPS + 1;    // quotient including the limit
  localparam logic [QUOT_W-1:0] QUOT_SAT = {1'b1, {DIV_STEPS{1'b0}}};

  localparam int TEMP_W = 16;

  // side information that rides along with the division
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     pvalid;
    logic                     neg;
  } bpc_tag_t;

endpackage

/* hdl/bpc_div.sv */
// ----------------------------------------------------------------------------
// bpc_div
// pipelined restoring divider, one quotient bit per stage, quotient limited
// to 2^35
// ----------------------------------------------------------------------------
module bpc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_v,
  input  bpc_pkg::bpc_tag_t         in_tag,
  input  logic [bpc_pkg::NUM_W-1:0] dividend,
  input  logic [bpc_pkg::DEN_W-1:0] divisor,
  output logic                      out_v,
  output bpc_pkg::bpc_tag_t         out_tag,
  output logic [bpc_pkg::QUOT_W-1:0] quot
);
  import bpc_pkg::*;

  logic [DIV_STEPS:0] dv;
  logic [DEN_W-1:0]     rem  [0:DIV_STEPS];
  logic [DEN_W-1:0]     den  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] nlo  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] qb   [0:DIV_STEPS];
  logic                 sat  [0:DIV_STEPS];
  bpc_tag_t             tag  [0:DIV_STEPS];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (en) begin
      dv <= {dv[DIV_STEPS-1:0], in_v};
    end
  end

  // entry stage: limit check, upper bits form the first partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= dividend[NUM_W-1:DIV_STEPS] >= {1'b0, divisor};
      rem[0] <= dividend[NUM_W-2:DIV_STEPS];
      nlo[0] <= dividend[DIV_STEPS-1:0];
      den[0] <= divisor;
      qb[0]  <= '0;
      tag[0] <= in_tag;
    end
  end

  // one compare and subtract per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DEN_W:0] rs;
    logic           ge;

    assign rs = {rem[k-1], nlo[k-1][DIV_STEPS-k]};
    assign ge = rs >= {1'b0, den[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DEN_W'(rs - {1'b0, den[k-1]}) : rs[DEN_W-1:0];
        qb[k]  <= {qb[k-1][DIV_STEPS-2:0], ge};
        nlo[k] <= nlo[k-1];
        den[k] <= den[k-1];
        sat[k] <= sat[k-1];
        tag[k] <= tag[k-1];
      end
    end
  end

  assign out_v   = dv[DIV_STEPS];
  assign out_tag = tag[DIV_STEPS];
  assign quot    = sat[DIV_STEPS] ? QUOT_SAT : {1'b0, qb[DIV_STEPS]};

endmodule

/* hdl/barometric_pressure_compensation_top.sv */
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// integer temperature and pressure compensation of raw barometer conversions
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carries one request of raw_temperature
//   and raw_pressure. output channel: out_valid/out_ready carries
//   temperature_centi, pressure_q24_8 and pressure_valid.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data writes the
//   four 48-bit trim registers; indexes above 3 are dropped. cfg_ready is
//   always high. write trims only while no request is in flight.
//   throughput: one request per cycle while the skid buffer is empty, fully pipelined.
//   pipeline: 11 front stages, the 36-stage divider (one quotient bit per
//   stage) and 3 back stages, then the output register.
//   reset clears all trims to zero and empties the pipeline.
//   receiver stall: the pipeline keeps running into a one-entry skid buffer
//   behind the output register; in_ready drops only once that buffer is full,
//   and the whole pipeline then holds without losing any request.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::TRIM_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [19:0]                   raw_temperature,
  input  logic [19:0]                   raw_pressure,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            temperature_centi,
  output logic [31:0]                   pressure_q24_8,
  output logic                          pressure_valid
);
  import bpc_pkg::*;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [31:0]              pres;
    logic                     pval;
  } res_t;

  // trim registers
  logic [TRIM_W-1:0] temp_trim, press_trim_a, press_trim_b, press_trim_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim    <= '0;
      press_trim_a <= '0;
      press_trim_b <= '0;
      press_trim_c <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEMP_TRIM: temp_trim    <= cfg_data;
        CFG_PRESS_A:   press_trim_a <= cfg_data;
        CFG_PRESS_B:   press_trim_b <= cfg_data;
        CFG_PRESS_C:   press_trim_c <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_trim[15:0];
  assign t2 = temp_trim[31:16];
  assign t3 = temp_trim[47:32];
  assign p1 = press_trim_a[15:0];
  assign p2 = press_trim_a[31:16];
  assign p3 = press_trim_a[47:32];
  assign p4 = press_trim_b[15:0];
  assign p5 = press_trim_b[31:16];
  assign p6 = press_trim_b[47:32];
  assign p7 = press_trim_c[15:0];
  assign p8 = press_trim_c[31:16];
  assign p9 = press_trim_c[47:32];

  // pipeline control
  logic        en, in_fire;
  logic [10:0] fv;
  logic [2:0]  pv;
  logic        div_v;
  logic        out_v, sk_v;
  res_t        out_r, sk_r, pipe_res;

  assign en       = !sk_v;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      pv <= '0;
    end else if (en) begin
      fv <= {fv[9:0], in_fire};
      pv <= {pv[1:0], div_v};
    end
  end

  // front stage registers
  logic signed [17:0] s1_dt;
  logic signed [16:0] s1_db;
  logic signed [33:0] s2_pa;
  logic [31:0]        s2_bsq;
  logic signed [22:0] s3_a1;
  logic signed [36:0] s3_bt;
  logic signed [23:0] s4_tf;
  logic signed [15:0] s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic signed [24:0] s5_v;
  logic [47:0]        s6_vv;
  logic signed [40:0] s6_vp5, s6_vp2, s7_vp5, s7_vp2;
  logic signed [64:0] s7_w6, s7_a3;
  logic signed [65:0] s8_w;
  logic signed [57:0] s8_a;
  logic signed [66:0] s9_num;
  logic signed [41:0] s9_dh, s10_den;
  logic [48:0]        s9_dl;
  logic [65:0]        s10_mag;
  logic               s10_nneg;
  logic [NUM_W-1:0]   s11_n;
  logic [DEN_W-1:0]   s11_d;
  bpc_tag_t           s11_tag;
  logic [19:0]        s1_adp, s2_adp, s3_adp, s4_adp, s5_adp, s6_adp, s7_adp, s8_adp;

  logic signed [33:0] db_sq;
  logic signed [26:0] tf5;
  logic signed [18:0] t_sh;
  logic signed [15:0] t_sat;
  logic signed [49:0] v_sq;

  assign db_sq = s1_db * s1_db;
  assign tf5   = 27'(s4_tf) * 27'sd5 + 27'sd128;
  assign t_sh  = tf5[26:8];
  assign v_sq  = s5_v * s5_v;

  // temperature saturation to 16 bits
  always_comb begin
    if (t_sh > 19'sd32767) begin
      t_sat = 16'sh7fff;
    end else if (t_sh < -19'sd32768) begin
      t_sat = 16'sh8000;
    end else begin
      t_sat = t_sh[15:0];
    end
  end

  // temperature path, fine temperature, pressure offset, numerator and divisor
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dt  <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
      s1_db  <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
      s1_adp <= raw_pressure;

      s2_pa  <= s1_dt * t2;
      s2_bsq <= db_sq[31:0];
      s2_adp <= s1_adp;

      s3_a1  <= 23'(s2_pa >>> 11);
      s3_bt  <= $signed({1'b0, s2_bsq[31:12]}) * t3;
      s3_adp <= s2_adp;

      s4_tf  <= 24'(s3_a1) + 24'(s3_bt >>> 14);
      s4_adp <= s3_adp;

      s5_temp <= t_sat;
      s5_v    <= 25'(s4_tf) - 25'sd128000;
      s5_adp  <= s4_adp;

      s6_vv   <= v_sq[47:0];
      s6_vp5  <= s5_v * p5;
      s6_vp2  <= s5_v * p2;
      s6_temp <= s5_temp;
      s6_adp  <= s5_adp;

      s7_w6   <= $signed({1'b0, s6_vv}) * p6;
      s7_a3   <= $signed({1'b0, s6_vv}) * p3;
      s7_vp5  <= s6_vp5;
      s7_vp2  <= s6_vp2;
      s7_temp <= s6_temp;
      s7_adp  <= s6_adp;

      s8_w    <= 66'(s7_w6) + (66'(s7_vp5) <<< 17) + (66'(p4) <<< 35);
      s8_a    <= 58'(s7_a3 >>> 8) + (58'(s7_vp2) <<< 12) + (58'sd1 <<< 47);
      s8_temp <= s7_temp;
      s8_adp  <= s7_adp;

      s9_num  <= 67'($signed({1'b0, 21'(21'd1048576 - 21'(s8_adp)), 31'd0})) - 67'(s8_w);
      s9_dh   <= $signed(s8_a[57:33]) * $signed({1'b0, p1});
      s9_dl   <= s8_a[32:0] * p1;
      s9_temp <= s8_temp;

      s10_den  <= s9_dh + 42'($signed({1'b0, s9_dl[48:33]}));
      s10_mag  <= s9_num[66] ? 66'(-s9_num) : 66'(s9_num);
      s10_nneg <= s9_num[66];
      s10_temp <= s9_temp;

      s11_n          <= s10_mag * 12'd3125;
      s11_d          <= s10_den[41] ? DEN_W'(-s10_den) : DEN_W'(s10_den);
      s11_tag.temp   <= s10_temp;
      s11_tag.pvalid <= s10_den != '0;
      s11_tag.neg    <= s10_nneg ^ s10_den[41];
    end
  end

  // pressure division
  bpc_tag_t          div_tag;
  logic [QUOT_W-1:0] div_q;

  bpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (fv[10]),
    .in_tag   (s11_tag),
    .dividend (s11_n),
    .divisor  (s11_d),
    .out_v    (div_v),
    .out_tag  (div_tag),
    .quot     (div_q)
  );

  // back stages: second-order pressure correction
  logic signed [36:0] q1_p, q2_p, q3_p;
  logic [44:0]        q2_aa;
  logic signed [52:0] q2_p8p, q3_p8p;
  logic signed [61:0] q3_a9;
  bpc_tag_t           q1_tag, q2_tag, q3_tag;

  logic signed [23:0] a13;
  logic signed [47:0] a_sq;

  assign a13  = 24'(q1_p >>> 13);
  assign a_sq = a13 * a13;

  always_ff @(posedge clk) begin
    if (en) begin
      q1_p   <= div_tag.neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      q1_tag <= div_tag;

      q2_aa  <= a_sq[44:0];
      q2_p8p <= q1_p * p8;
      q2_p   <= q1_p;
      q2_tag <= q1_tag;

      q3_a9  <= $signed({1'b0, q2_aa}) * p9;
      q3_p8p <= q2_p8p;
      q3_p   <= q2_p;
      q3_tag <= q2_tag;
    end
  end

  logic signed [38:0] psum;
  logic signed [32:0] pr;

  assign psum = 39'(q3_p) + 39'(q3_a9 >>> 25) + 39'(q3_p8p >>> 19);
  assign pr   = 33'(psum >>> 8) + (33'(p7) <<< 4);

  // final clamp, zero when the divisor was zero
  always_comb begin
    pipe_res.temp = q3_tag.temp;
    pipe_res.pval = q3_tag.pvalid;
    if (!q3_tag.pvalid || pr[32]) begin
      pipe_res.pres = '0;
    end else begin
      pipe_res.pres = pr[31:0];
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (!out_v || out_ready) begin
      if (sk_v) begin
        out_v <= 1'b1;
        sk_v  <= 1'b0;
      end else begin
        out_v <= pv[2];
      end
    end else if (pv[2] && en) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || out_ready) begin
      out_r <= sk_v ? sk_r : pipe_res;
    end
    if (out_v && !out_ready && !sk_v) begin
      sk_r <= pipe_res;
    end
  end

  assign out_valid         = out_v;
  assign temperature_centi = out_r.temp;
  assign pressure_q24_8    = out_r.pres;
  assign pressure_valid    = out_r.pval;

  // checks
  skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_v)
    else $error("skid entry held while output register empty");

  invalid_pressure_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressure_valid |-> pressure_q24_8 == '0)
    else $error("pressure nonzero with zero divisor");

  skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(sk_v) |-> $past(out_v && !out_ready))
    else $error("skid filled without a stalled output");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the barometric pressure compensation block: a
// directed table of trim writes and raw conversions, then random trim sets
// with random raw pairs, each result compared against its table entry or an integer predictor
// ----------------------------------------------------------------------------
module tb;
  import bpc_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [15:0] temp;
    logic [31:0]        pres;
    logic               pvalid;
  } comp_result_t;

  typedef enum logic { ROW_TRIM, ROW_SAMPLE } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [2:0]         index;
    logic [47:0]        data;
    logic [19:0]        raw_t;
    logic [19:0]        raw_p;
    logic               known;
    logic signed [15:0] e_temp;
    logic [31:0]        e_pres;
    logic               e_valid;
  } stim_row_t;

  localparam int LATENCY    = 50;
  localparam int STALL_MAX  = 4;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 155;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TRIM_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [19:0]          raw_temperature = '0;
  logic [19:0]          raw_pressure = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [15:0]   temperature_centi;
  logic [31:0]          pressure_q24_8;
  logic                 pressure_valid;

  // own copy of the trim registers
  logic [47:0] temp_trim_q, press_a_q, press_b_q, press_c_q;

  comp_result_t comp_expected_q[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           calm = 1'b0;

  barometric_pressure_compensation_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
    .out_valid(out_valid), .out_ready(out_ready),
    .temperature_centi(temperature_centi),
    .pressure_q24_8(pressure_q24_8), .pressure_valid(pressure_valid)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t sx16(logic [15:0] x);
    return {{112{x[15]}}, x};
  endfunction

  function automatic wide_t ux16(logic [15:0] x);
    return {112'b0, x};
  endfunction

  // full-precision integer compensation of one raw pair
  function automatic comp_result_t predict_compensation(logic [19:0] rt, logic [19:0] rp);
    wide_t        at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    wide_t        a, b, tf, tc, v, w, dv, num, nm, dm, q, p, pr;
    comp_result_t r;
    at = {108'b0, rt};
    ap = {108'b0, rp};
    t1 = ux16(temp_trim_q[15:0]);
    t2 = sx16(temp_trim_q[31:16]);
    t3 = sx16(temp_trim_q[47:32]);
    p1 = ux16(press_a_q[15:0]);
    p2 = sx16(press_a_q[31:16]);
    p3 = sx16(press_a_q[47:32]);
    p4 = sx16(press_b_q[15:0]);
    p5 = sx16(press_b_q[31:16]);
    p6 = sx16(press_b_q[47:32]);
    p7 = sx16(press_c_q[15:0]);
    p8 = sx16(press_c_q[31:16]);
    p9 = sx16(press_c_q[47:32]);
    // temperature path
    a  = (((at >>> 3) - t1 * 2) * t2) >>> 11;
    b  = (at >>> 4) - t1;
    b  = (((b * b) >>> 12) * t3) >>> 14;
    tf = a + b;
    tc = (tf * 5 + 128) >>> 8;
    if (tc > 32767) tc = 32767;
    if (tc < -32768) tc = -32768;
    r.temp = tc[15:0];
    r.pres = '0;
    r.pvalid = 1'b0;
    // pressure divisor, division and correction
    v  = tf - 128000;
    w  = v * v * p6 + v * p5 * 131072 + p4 * (wide_t'(1) <<< 35);
    a  = ((v * v * p3) >>> 8) + v * p2 * 4096;
    a  = (wide_t'(1) <<< 47) + a;
    dv = (a * p1) >>> 33;
    if (dv != 0) begin
      num = (1048576 - ap) * (wide_t'(1) <<< 31) - w;
      nm = (num < 0) ? -num : num;
      dm = (dv < 0) ? -dv : dv;
      q = (nm * 3125) / dm;
      if (q > (wide_t'(1) <<< 35)) q = wide_t'(1) <<< 35;
      p = ((num < 0) != (dv < 0)) ? -q : q;
      a = p >>> 13;
      a = (p9 * a * a) >>> 25;
      b = (p8 * p) >>> 19;
      pr = ((p + a + b) >>> 8) + p7 * 16;
      if (pr < 0) pr = 0;
      if (pr > 64'hFFFF_FFFF) pr = 64'hFFFF_FFFF;
      r.pres = pr[31:0];
      r.pvalid = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // result checking
  always @(posedge clk) begin
    comp_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (comp_expected_q.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        e = comp_expected_q.pop_front();
        if (temperature_centi !== e.temp)
          report_mismatch($sformatf("temperature_centi %0d, want %0d",
                                    temperature_centi, e.temp));
        if (pressure_q24_8 !== e.pres)
          report_mismatch($sformatf("pressure_q24_8 %0h, want %0h",
                                    pressure_q24_8, e.pres));
        if (pressure_valid !== e.pvalid)
          report_mismatch($sformatf("pressure_valid %0b, want %0b",
                                    pressure_valid, e.pvalid));
      end
    end
  end

  // watchdog on cycles without any handshake on the input, output or configuration port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver with random stalls
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = calm ? 0 : $urandom_range(0, STALL_MAX);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // trim write, only with nothing in flight
  task automatic write_trim(input logic [2:0] idx, input logic [47:0] value);
    while (comp_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TEMP_TRIM: temp_trim_q = value;
      CFG_PRESS_A:   press_a_q = value;
      CFG_PRESS_B:   press_b_q = value;
      CFG_PRESS_C:   press_c_q = value;
      default: ;
    endcase
  endtask

  // one raw pair request; valid is left high for the next caller
  task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
                             input logic known, input comp_result_t typed);
    int gap;
    gap = calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_temperature <= rt;
    raw_pressure <= rp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    comp_expected_q.push_back(known ? typed : predict_compensation(rt, rp));
  endtask

  function automatic stim_row_t trim_row(logic [2:0] idx, logic [47:0] value);
    stim_row_t r;
    r = '{ROW_TRIM, idx, value, 20'd0, 20'd0, 1'b0, 16'sd0, 32'd0, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t sample_row(logic [19:0] rt, logic [19:0] rp, logic known,
                                           logic signed [15:0] et, logic [31:0] ep,
                                           logic ev);
    stim_row_t r;
    r = '{ROW_SAMPLE, 3'd0, 48'd0, rt, rp, known, et, ep, ev};
    return r;
  endfunction

  function automatic logic [47:0] random_trim_set_field();
    return 48'({$urandom, $urandom});
  endfunction

  initial begin
    stim_row_t    dir_rows[$];
    comp_result_t typed;
    logic [47:0]  tt, pa, pb, pc;
    logic [19:0]  rt, rp;
    int           k;

    temp_trim_q = '0;
    press_a_q = '0;
    press_b_q = '0;
    press_c_q = '0;

    // directed: zero trims after reset, saturations, typical trims, bad index
    dir_rows.push_back(sample_row(20'd0, 20'd0, 1'b1, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(sample_row(20'hFFFFF, 20'hFFFFF, 1'b1, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(sample_row(20'h00000, 20'hFFFFF, 1'b1, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(sample_row(20'hAAAAA, 20'h55555, 1'b1, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(trim_row(CFG_TEMP_TRIM, {16'sd32767, 16'sd32767, 16'd0}));
    dir_rows.push_back(sample_row(20'hFFFFF, 20'd0, 1'b1, 16'sh7FFF, 32'd0, 1'b0));
    dir_rows.push_back(trim_row(CFG_TEMP_TRIM, {16'd0, 16'h8000, 16'd0}));
    dir_rows.push_back(sample_row(20'hFFFFF, 20'd0, 1'b1, 16'sh8000, 32'd0, 1'b0));
    dir_rows.push_back(trim_row(CFG_TEMP_TRIM, {16'hFC18, 16'd26435, 16'd27504}));
    dir_rows.push_back(trim_row(CFG_PRESS_A, {16'd3024, 16'hD643, 16'd36477}));
    dir_rows.push_back(trim_row(CFG_PRESS_B, {16'hFFF9, 16'd140, 16'd2855}));
    dir_rows.push_back(trim_row(CFG_PRESS_C, {16'd6000, 16'hC708, 16'd15500}));
    dir_rows.push_back(sample_row(20'd519888, 20'd415148, 1'b0, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(sample_row(20'd0, 20'd0, 1'b0, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(sample_row(20'hFFFFF, 20'hFFFFF, 1'b0, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(sample_row(20'hFFFFF, 20'd0, 1'b0, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(sample_row(20'd0, 20'hFFFFF, 1'b0, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(trim_row(3'd4, 48'hFFFF_FFFF_FFFF));
    dir_rows.push_back(trim_row(3'd7, 48'h0000_0000_0000));
    dir_rows.push_back(sample_row(20'd519888, 20'd415148, 1'b0, 16'sd0, 32'd0, 1'b0));
    dir_rows.push_back(trim_row(CFG_PRESS_A, {16'd3024, 16'hD643, 16'd0}));
    dir_rows.push_back(sample_row(20'd519888, 20'd415148, 1'b1, 16'sd0, 32'd0, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table walk
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_TRIM) begin
        in_valid <= 1'b0;
        write_trim(dir_rows[i].index, dir_rows[i].data);
      end else begin
        typed = '{dir_rows[i].e_temp, dir_rows[i].e_pres, dir_rows[i].e_valid};
        if (dir_rows[i].known && dir_rows[i].e_temp == 0) begin
          // zero-temperature rows hold only under the trims at the time of the row
          typed.temp = predict_compensation(dir_rows[i].raw_t, dir_rows[i].raw_p).temp;
        end
        send_sample(dir_rows[i].raw_t, dir_rows[i].raw_p, dir_rows[i].known, typed);
      end
    end

    // random phases, each with its own trim set
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          tt = {16'hFC18, 16'd26435, 16'd27504};
          pa = {16'd3024, 16'hD643, 16'd36477};
          pb = {16'hFFF9, 16'd140, 16'd2855};
          pc = {16'd6000, 16'hC708, 16'd15500};
        end
        1: begin
          tt = {16'h7FFF, 16'h7FFF, 16'hFFFF};
          pa = {16'h7FFF, 16'h7FFF, 16'hFFFF};
          pb = {3{16'h7FFF}};
          pc = {3{16'h7FFF}};
        end
        2: begin
          tt = {16'h8000, 16'h8000, 16'h0000};
          pa = {16'h8000, 16'h8000, 16'h0001};
          pb = {3{16'h8000}};
          pc = {3{16'h8000}};
        end
        3: begin
          tt = 48'hFFFF_FFFF_FFFF;
          pa = 48'hFFFF_FFFF_FFFF;
          pb = 48'hFFFF_FFFF_FFFF;
          pc = 48'hFFFF_FFFF_FFFF;
        end
        4: begin
          // zero divisor throughout
          tt = random_trim_set_field();
          pa = random_trim_set_field();
          pa[15:0] = 16'd0;
          pb = random_trim_set_field();
          pc = random_trim_set_field();
        end
        default: begin
          if (ph % 2 == 1) begin
            tt = random_trim_set_field();
            pa = random_trim_set_field();
            pb = random_trim_set_field();
            pc = random_trim_set_field();
          end else begin
            // realistic trims with a little spread
            tt = {16'hFC18 + 16'($urandom_range(0, 400)), 16'd26000
                  + 16'($urandom_range(0, 900)), 16'd27000 + 16'($urandom_range(0, 1000))};
            pa = {16'd2800 + 16'($urandom_range(0, 400)), 16'hD400
                  + 16'($urandom_range(0, 1000)), 16'd36000 + 16'($urandom_range(0, 1000))};
            pb = {16'hFFF0 + 16'($urandom_range(0, 15)), 16'd100
                  + 16'($urandom_range(0, 80)), 16'd2500 + 16'($urandom_range(0, 700))};
            pc = {16'd5500 + 16'($urandom_range(0, 1000)), 16'hC500
                  + 16'($urandom_range(0, 1000)), 16'd15000 + 16'($urandom_range(0, 1000))};
          end
        end
      endcase
      in_valid <= 1'b0;
      write_trim(CFG_TEMP_TRIM, tt);
      write_trim(CFG_PRESS_A, pa);
      write_trim(CFG_PRESS_B, pb);
      write_trim(CFG_PRESS_C, pc);
      if ($urandom_range(0, 2) == 0) write_trim(3'($urandom_range(4, 7)), random_trim_set_field());
      calm = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_LEN; k++) begin
        if (k % 40 == 20) calm = !calm;
        case ($urandom_range(0, 3))
          0: begin
            rt = 20'($urandom);
            rp = 20'($urandom);
          end
          1: begin
            rt = 20'd519888 + 20'($urandom_range(0, 60000)) - 20'd30000;
            rp = 20'd415148 + 20'($urandom_range(0, 200000)) - 20'd100000;
          end
          2: begin
            rt = $urandom_range(0, 1) ? 20'hFFFFF - 20'($urandom_range(0, 15))
                                      : 20'($urandom_range(0, 15));
            rp = 20'($urandom);
          end
          default: begin
            rt = 20'($urandom);
            rp = $urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom_range(0, 15));
          end
        endcase
        typed = '{16'sd0, 32'd0, 1'b0};
        send_sample(rt, rp, 1'b0, typed);
      end
      calm = 1'b0;
    end
    in_valid <= 1'b0;

    // drain
    while (comp_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (comp_expected_q.size() != 0) report_mismatch("results still outstanding");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bpc_pkg.sv
hdl/bpc_div.sv
hdl/barometric_pressure_compensation_top.sv
tb/sv/tb.sv
